>>> sv/sst_pkg.sv
`timescale 1ns / 1ps
package sst_pkg;
    localparam int MAX_KEYWORD_LEN_DEF = 8;
    localparam int LINE_BITS_DEF = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        KIND_IDENT = 4'd0,
        KIND_KEYWORD = 4'd1,
        KIND_BOOLEAN = 4'd2,
        KIND_NULL = 4'd3,
        KIND_NUMBER = 4'd4,
        KIND_STRING = 4'd5,
        KIND_OPERATOR = 4'd6,
        KIND_PUNCT = 4'd7,
        KIND_ERROR = 4'd8,
        KIND_END = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        MD_IDLE = 4'd0,
        MD_LCOM = 4'd1,
        MD_BSTAR = 4'd2,
        MD_BBODY = 4'd3,
        MD_BCLOSE = 4'd4,
        MD_IDENT = 4'd5,
        MD_NUM = 4'd6,
        MD_STR = 4'd7,
        MD_ESC = 4'd8,
        MD_OP2 = 4'd9
    } mode_t;

    // one queued pair: byte being lexed, lookahead, end flag
    typedef struct packed {
        logic [7:0] c;
        logic [7:0] p;
        logic       has_c;
        logic       is_end;
    } pair_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5f;
    endfunction

    function automatic logic num_char(input logic [7:0] c);
        return is_digit(c) || c == 8'h2e;
    endfunction
endpackage

>>> sv/sst_if.sv
`timescale 1ns / 1ps
interface sst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_end;
    modport source(output valid, output in_char, output in_end, input ready);
    modport sink(input valid, input in_char, input in_end, output ready);
endinterface

interface sst_out_if #(
    parameter int LINE_BITS = 20,
    parameter int COLUMN_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [7:0]             tok_byte;
    logic                   has_byte;
    logic [3:0]             tok_kind;
    logic                   first_of_token;
    logic                   last_of_token;
    logic [LINE_BITS-1:0]   line_no;
    logic [COLUMN_BITS-1:0] column_no;
    modport source(output valid, output tok_byte, output has_byte, output tok_kind,
        output first_of_token, output last_of_token, output line_no,
        output column_no, input ready);
    modport sink(input valid, input tok_byte, input has_byte, input tok_kind,
        input first_of_token, input last_of_token, input line_no,
        input column_no, output ready);
endinterface

>>> sv/sst_front.sv
`timescale 1ns / 1ps
module sst_front (
    input  logic          clk,
    input  logic          rst_n,
    sst_in_if.sink        in_ch,
    output logic          q_push,
    output sst_pkg::pair_t q_data,
    input  logic          q_full
);
    import sst_pkg::*;

    logic [7:0] pend_reg;
    logic       pend_valid_reg;
    logic       is_end;

    assign in_ch.ready = !q_full;
    assign is_end = in_ch.in_end || in_ch.in_char == 8'h00;
    assign q_push = in_ch.valid && !q_full && (is_end || pend_valid_reg);
    assign q_data.c = pend_reg;
    assign q_data.p = is_end ? 8'h00 : in_ch.in_char;
    assign q_data.has_c = pend_valid_reg;
    assign q_data.is_end = is_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 8'h00;
            pend_valid_reg <= 1'b0;
        end
        else if (in_ch.valid && !q_full)
        begin
            pend_reg <= is_end ? 8'h00 : in_ch.in_char;
            pend_valid_reg <= !is_end;
        end
    end
endmodule

>>> sv/sst_queue.sv
`timescale 1ns / 1ps
module sst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sst_pkg::pair_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sst_pkg::pair_t rdata
);
    import sst_pkg::*;
    localparam int AW = $clog2(QUEUE_DEPTH);

    pair_t         mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full = cnt_reg == (AW+1)'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rdata = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> sv/sst_back.sv
`timescale 1ns / 1ps
module sst_back #(
    parameter int MAX_KEYWORD_LEN = sst_pkg::MAX_KEYWORD_LEN_DEF,
    parameter int LINE_BITS = sst_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = sst_pkg::COLUMN_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  sst_pkg::pair_t q_data,
    output logic           q_pop,
    sst_out_if.source      out_ch
);
    import sst_pkg::*;
    localparam int PW = $clog2(MAX_KEYWORD_LEN + 2);
    localparam int PI = $clog2(MAX_KEYWORD_LEN);
    localparam logic [LINE_BITS-1:0] LTOP = '1;
    localparam logic [COLUMN_BITS-1:0] CTOP = '1;
    localparam int IW = 1 + 1 + 8 + 1 + 4 + 1 + 1 + LINE_BITS + COLUMN_BITS;

    typedef struct packed {
        logic [7:0]             b;
        logic                   has;
        logic [3:0]             kind;
        logic                   first;
        logic                   last;
        logic [LINE_BITS-1:0]   ln;
        logic [COLUMN_BITS-1:0] col;
    } item_t;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             pre_reg [MAX_KEYWORD_LEN];
    logic [PW-1:0]          plen_reg, plen_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic                   semit_reg, semit_next;
    logic                   pre_we;
    logic [7:0]             pre_wd;

    // output buffer: up to three items per pair
    item_t                  buf_reg [3];
    logic [1:0]             bn_reg, bidx_reg;
    item_t                  it [3];
    logic [1:0]             n;

    logic busy;
    assign busy = bn_reg != 2'd0;
    assign q_pop = q_valid && (!busy || (bidx_reg == bn_reg - 2'd1 && out_ch.ready));

    assign out_ch.valid = busy;
    assign out_ch.tok_byte = buf_reg[bidx_reg].b;
    assign out_ch.has_byte = buf_reg[bidx_reg].has;
    assign out_ch.tok_kind = buf_reg[bidx_reg].kind;
    assign out_ch.first_of_token = buf_reg[bidx_reg].first;
    assign out_ch.last_of_token = buf_reg[bidx_reg].last;
    assign out_ch.line_no = buf_reg[bidx_reg].ln;
    assign out_ch.column_no = buf_reg[bidx_reg].col;

    function automatic logic [LINE_BITS+COLUMN_BITS-1:0] cnt_over(
        input logic [LINE_BITS-1:0] l, input logic [COLUMN_BITS-1:0] c,
        input logic [7:0] ch);
        logic [LINE_BITS-1:0]   lo;
        logic [COLUMN_BITS-1:0] co;
        lo = l;
        co = c;
        if (ch == 8'h0a)
        begin
            if (l != LTOP) lo = l + 1'b1;
            co = COLUMN_BITS'(1);
        end
        else if (c != CTOP)
        begin
            co = c + 1'b1;
        end
        return {lo, co};
    endfunction

    function automatic logic [3:0] word_kind(
        input logic [7:0] w [MAX_KEYWORD_LEN], input logic [PW-1:0] len);
        logic [63:0] s;
        logic [3:0]  k;
        s = '0;
        k = KIND_IDENT;
        for (int i = 0; i < 8; i++)
        begin
            if (PW'(i) < len) s[63-8*i -: 8] = w[i];
        end
        if (len == PW'(4) && s[63:32] == "true") k = KIND_BOOLEAN;
        if (len == PW'(5) && s[63:24] == "false") k = KIND_BOOLEAN;
        if (len == PW'(4) && s[63:32] == "null") k = KIND_NULL;
        if (len == PW'(2) && s[63:48] == "if") k = KIND_KEYWORD;
        if (len == PW'(4) && s[63:32] == "else") k = KIND_KEYWORD;
        if (len == PW'(5) && s[63:24] == "while") k = KIND_KEYWORD;
        if (len == PW'(3) && s[63:40] == "for") k = KIND_KEYWORD;
        if (len == PW'(6) && s[63:16] == "return") k = KIND_KEYWORD;
        if (len == PW'(5) && s[63:24] == "break") k = KIND_KEYWORD;
        if (len == PW'(8) && s == "continue") k = KIND_KEYWORD;
        if (len == PW'(8) && s == "function") k = KIND_KEYWORD;
        if (len == PW'(3) && s[63:40] == "var") k = KIND_KEYWORD;
        if (len == PW'(5) && s[63:24] == "const") k = KIND_KEYWORD;
        if (len == PW'(3) && s[63:40] == "let") k = KIND_KEYWORD;
        return k;
    endfunction

    always_comb
    begin
        logic [7:0]             c, p, d;
        logic                   lst, two, redo, esc_ok;
        logic [LINE_BITS-1:0]   tl;
        logic [COLUMN_BITS-1:0] tc;
        logic [7:0]             w [MAX_KEYWORD_LEN];
        logic [PW-1:0]          wl;
        c = q_data.c;
        p = q_data.p;
        mode_next = mode_reg;
        plen_next = plen_reg;
        line_next = line_reg;
        col_next = col_reg;
        semit_next = semit_reg;
        pre_we = 1'b0;
        pre_wd = c;
        n = 2'd0;
        d = c;
        lst = 1'b0;
        two = 1'b0;
        redo = 1'b0;
        esc_ok = 1'b0;
        tl = '0;
        tc = '0;
        wl = '0;
        for (int i = 0; i < MAX_KEYWORD_LEN; i++)
        begin
            w[i] = pre_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            it[i] = '0;
        end
        if (q_data.has_c)
        begin
            if (mode_reg == MD_LCOM && c == 8'h0a) mode_next = MD_IDLE;
            if (mode_reg == MD_ESC)
            begin
                esc_ok = c == "n" || c == "t" || c == 8'h5c || c == 8'h22;
                d = c == "n" ? 8'h0a : (c == "t" ? 8'h09 : c);
                if (!esc_ok)
                begin
                    it[0] = '{8'h00, 1'b0, KIND_ERROR, !semit_reg, 1'b1, line_reg, col_reg};
                    n = 2'd1;
                    mode_next = MD_IDLE;
                    redo = 1'b1;
                end
            end
            {line_next, col_next} = cnt_over(line_reg, col_reg, c);
            unique case (mode_next)
                MD_LCOM:
                begin
                end
                MD_BSTAR:
                begin
                    mode_next = MD_BBODY;
                end
                MD_BBODY:
                begin
                    if (c == "*" && p == "/") mode_next = MD_BCLOSE;
                end
                MD_BCLOSE:
                begin
                    mode_next = MD_IDLE;
                end
                MD_IDENT, MD_NUM:
                begin
                    lst = mode_reg == MD_IDENT ? !ident_char(p) : !num_char(p);
                    if (mode_reg == MD_IDENT)
                    begin
                        if (plen_reg < PW'(MAX_KEYWORD_LEN))
                        begin
                            pre_we = 1'b1;
                            w[plen_reg[PI-1:0]] = c;
                        end
                        wl = plen_reg <= PW'(MAX_KEYWORD_LEN) ? plen_reg + 1'b1 : plen_reg;
                        plen_next = wl;
                    end
                    it[0] = '{c, 1'b1, mode_reg == MD_NUM ? KIND_NUMBER :
                        ((lst && wl <= PW'(MAX_KEYWORD_LEN)) ? word_kind(w, wl) : KIND_IDENT),
                        1'b0, lst, line_next, col_next};
                    n = 2'd1;
                    if (lst) mode_next = MD_IDLE;
                end
                MD_OP2:
                begin
                    it[0] = '{c, 1'b1, KIND_OPERATOR, 1'b0, 1'b1, line_next, col_next};
                    n = 2'd1;
                    mode_next = MD_IDLE;
                end
                MD_STR, MD_ESC:
                begin
                    if (mode_reg == MD_STR && c == 8'h22)
                    begin
                        if (!semit_reg)
                        begin
                            it[0] = '{8'h00, 1'b0, KIND_STRING, 1'b1, 1'b1, line_next, col_next};
                            n = 2'd1;
                        end
                        mode_next = MD_IDLE;
                    end
                    else if (mode_reg == MD_STR && c == 8'h5c)
                    begin
                        mode_next = MD_ESC;
                    end
                    else
                    begin
                        lst = p == 8'h22;
                        {tl, tc} = lst ? cnt_over(line_next, col_next, 8'h22)
                                       : {line_next, col_next};
                        it[0] = '{d, 1'b1, KIND_STRING, !semit_reg, lst, tl, tc};
                        n = 2'd1;
                        semit_next = 1'b1;
                        mode_next = MD_STR;
                    end
                end
                default:
                begin
                    if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d)
                    begin
                    end
                    else if (c == "/" && p == "/") mode_next = MD_LCOM;
                    else if (c == "/" && p == "*") mode_next = MD_BSTAR;
                    else if (is_alpha(c) || c == 8'h5f)
                    begin
                        lst = !ident_char(p);
                        pre_we = 1'b1;
                        w[0] = c;
                        plen_next = PW'(1);
                        it[n] = '{c, 1'b1, lst ? word_kind(w, PW'(1)) : KIND_IDENT,
                            1'b1, lst, line_next, col_next};
                        n = n + 2'd1;
                        if (!lst) mode_next = MD_IDENT;
                    end
                    else if (is_digit(c))
                    begin
                        lst = !num_char(p);
                        it[n] = '{c, 1'b1, KIND_NUMBER, 1'b1, lst, line_next, col_next};
                        n = n + 2'd1;
                        if (!lst) mode_next = MD_NUM;
                    end
                    else if (c == 8'h22)
                    begin
                        semit_next = 1'b0;
                        mode_next = MD_STR;
                    end
                    else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" ||
                             c == "|")
                    begin
                        two = p == "=" || (c == "&" && p == "&") || (c == "|" && p == "|");
                        it[n] = '{c, 1'b1, KIND_OPERATOR, 1'b1, !two, line_next, col_next};
                        n = n + 2'd1;
                        if (two) mode_next = MD_OP2;
                    end
                    else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%")
                    begin
                        it[n] = '{c, 1'b1, KIND_OPERATOR, 1'b1, 1'b1, line_next, col_next};
                        n = n + 2'd1;
                    end
                    else if (c == "(" || c == ")" || c == "{" || c == "}" || c == "[" ||
                             c == "]" || c == "," || c == ";" || c == ".")
                    begin
                        it[n] = '{c, 1'b1, KIND_PUNCT, 1'b1, 1'b1, line_next, col_next};
                        n = n + 2'd1;
                    end
                    else
                    begin
                        it[n] = '{8'h00, 1'b0, KIND_ERROR, 1'b1, 1'b1, line_next, col_next};
                        n = n + 2'd1;
                    end
                end
            endcase
        end
        if (q_data.is_end)
        begin
            if (mode_next == MD_STR || mode_next == MD_ESC)
            begin
                it[n] = '{8'h00, 1'b0, KIND_ERROR, !semit_next, 1'b1, line_next, col_next};
                n = n + 2'd1;
            end
            it[n] = '{8'h00, 1'b0, KIND_END, 1'b1, 1'b1, line_next, col_next};
            n = n + 2'd1;
            mode_next = MD_IDLE;
            plen_next = '0;
            line_next = LINE_BITS'(1);
            col_next = COLUMN_BITS'(1);
            semit_next = 1'b0;
        end
        pre_wd = c;
        if (redo) pre_we = pre_we;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && pre_we)
        begin
            pre_reg[mode_reg == MD_IDENT ? plen_reg[PI-1:0] : '0] <= pre_wd;
        end
        if (q_pop)
        begin
            for (int i = 0; i < 3; i++)
            begin
                buf_reg[i] <= it[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MD_IDLE;
            plen_reg <= '0;
            line_reg <= LINE_BITS'(1);
            col_reg <= COLUMN_BITS'(1);
            semit_reg <= 1'b0;
            bn_reg <= 2'd0;
            bidx_reg <= 2'd0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg <= mode_next;
                plen_reg <= plen_next;
                line_reg <= line_next;
                col_reg <= col_next;
                semit_reg <= semit_next;
                bn_reg <= n;
                bidx_reg <= 2'd0;
            end
            else if (busy && out_ch.ready)
            begin
                if (bidx_reg == bn_reg - 2'd1)
                begin
                    bn_reg <= 2'd0;
                    bidx_reg <= 2'd0;
                end
                else
                begin
                    bidx_reg <= bidx_reg + 2'd1;
                end
            end
        end
    end
endmodule

>>> sv/script_source_tokenizer_unit.sv
`timescale 1ns / 1ps
// Source tokenizer.
// in_ch carries one source byte per beat (in_char, in_end); in_end or a zero
// byte ends the source, flushes the held byte and yields an end token.
// out_ch carries one token byte per beat with kind, first/last marks and the
// saturating line and column after it.
// A front stage holds one byte of lookahead and pushes (byte, next byte)
// pairs into a four-entry queue; the back stage lexes one pair per cycle
// while the receiver is ready, and holds up to three result beats in an
// output buffer. Throughput: one input beat per cycle while each pair makes
// at most one result and the receiver is ready; a pair that makes two or
// three results holds the back stage until all are taken. The lookahead
// byte is queued, then its first result is registered in the output buffer.
// A stalled receiver fills the queue, then in_ch.ready drops.
// Reset empties the queue and returns to line 1, column 1, between tokens.
module script_source_tokenizer_unit #(
    parameter int MAX_KEYWORD_LEN = sst_pkg::MAX_KEYWORD_LEN_DEF,
    parameter int LINE_BITS = sst_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = sst_pkg::COLUMN_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    sst_in_if.sink    in_ch,
    sst_out_if.source out_ch
);
    import sst_pkg::*;

    logic  push, full, pop, nempty;
    pair_t wd, rd;

    sst_front u_front (.clk, .rst_n, .in_ch, .q_push(push), .q_data(wd), .q_full(full));
    sst_queue u_queue (.clk, .rst_n, .push, .wdata(wd), .full, .pop, .not_empty(nempty),
        .rdata(rd));
    sst_back #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .LINE_BITS(LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)) u_back (.clk, .rst_n, .q_valid(nempty), .q_data(rd),
        .q_pop(pop), .out_ch);
endmodule

>>> sv/sst_checker.sv
`timescale 1ns / 1ps
module sst_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       has_byte,
    input logic [3:0] tok_kind,
    input logic       last_of_token,
    input logic [7:0] tok_byte
);
    import sst_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tok_byte))
        else $error("output beat dropped while stalled");
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tok_kind == KIND_END |-> !has_byte && last_of_token)
        else $error("end token malformed");
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tok_kind == KIND_ERROR |-> !has_byte && last_of_token)
        else $error("error token malformed");
    a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> tok_byte == 8'h00)
        else $error("empty beat carries a byte");
endmodule

bind script_source_tokenizer_unit sst_checker u_chk (.clk, .rst_n,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .has_byte(out_ch.has_byte),
    .tok_kind(out_ch.tok_kind), .last_of_token(out_ch.last_of_token),
    .tok_byte(out_ch.tok_byte));
